// ----- hdl/fitness_selection_sorter_defines.svh -----
// Assertion macros shared by the checker.
`ifndef FITNESS_SELECTION_SORTER_DEFINES_SVH
`define FITNESS_SELECTION_SORTER_DEFINES_SVH

// Checked while out of reset.
`define FSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fitness_selection_sorter: assertion failed");

// Checked at every edge, reset included.
`define FSS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fitness_selection_sorter: reset assertion failed");

`endif

// ----- hdl/fss_pkg.sv -----
`timescale 1ns / 1ps
package fss_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int KEY_W = 64;
  localparam int RANK_W = 5;
  localparam logic [KEY_W-1:0] CEILING_RESET = 64'h4341_C379_37E0_8000;

  typedef struct packed {
    logic [KEY_W-1:0] fitness_key;
    logic             is_last;
  } in_beat_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] entry_index;
    logic [KEY_W-1:0]  sorted_key;
    logic              final_result;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_run;
    logic capture;
    logic advance;
    logic set_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last_rank;
  } ctrl_sts_t;

endpackage

// ----- hdl/fitness_selection_sorter.sv -----
`timescale 1ns / 1ps
// Selection sorter for up to ENTRIES 64-bit fitness keys (nonnegative double
// bit patterns, compared as unsigned). Keys load one per input beat at one
// beat per cycle; beats past capacity are dropped. The beat marked is_last
// starts the sort and the input stalls until the whole run is out. Each result
// beat costs a full scan of the n stored keys through the single read port of
// the key RAM; the next scan starts only once the result beat is taken. Keys
// below the ceiling come first in ascending order (lowest index on ties); the
// rest follow in index order, key clamped to the ceiling. The ceiling register
// (cfg_ready is always high) resets to 1e16.
module fitness_selection_sorter #(
  parameter int ENTRIES = fss_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  fss_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fss_pkg::out_beat_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fss_pkg::KEY_W-1:0] cfg_data
);

  fss_pkg::ctrl_cmd_t cmd;
  fss_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  fss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.is_last),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fss_datapath #(
    .ENTRIES(ENTRIES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_data (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .out_data(out_data)
  );

endmodule

// ----- hdl/fss_ram.sv -----
`timescale 1ns / 1ps
module fss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/fss_ctrl.sv -----
`timescale 1ns / 1ps
module fss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fss_pkg::ctrl_sts_t sts,
  output fss_pkg::ctrl_cmd_t cmd
);

  fss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fss_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fss_pkg::ST_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = fss_pkg::ST_SCAN;
        end
      end
      fss_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = fss_pkg::ST_EMIT;
        end
      end
      fss_pkg::ST_EMIT: begin
        if (out_ready) begin
          state_nxt = sts.last_rank ? fss_pkg::ST_LOAD : fss_pkg::ST_SCAN;
        end
      end
      default: state_nxt = fss_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      fss_pkg::ST_LOAD: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid;
        cmd.scan_clear = in_valid && in_last;
      end
      fss_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.capture  = sts.scan_done;
      end
      fss_pkg::ST_EMIT: begin
        out_valid      = 1'b1;
        cmd.advance    = out_ready;
        cmd.set_clear  = out_ready && sts.last_rank;
        cmd.scan_clear = out_ready && !sts.last_rank;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/fss_datapath.sv -----
`timescale 1ns / 1ps
module fss_datapath #(
  parameter int ENTRIES = fss_pkg::ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fss_pkg::ctrl_cmd_t       cmd,
  output fss_pkg::ctrl_sts_t       sts,
  input  fss_pkg::in_beat_t        in_data,
  input  logic                     cfg_we,
  input  logic [fss_pkg::KEY_W-1:0] cfg_data,
  output fss_pkg::out_beat_t       out_data
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int KW = fss_pkg::KEY_W;

  logic [KW-1:0]      ceiling_r, ceiling_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      rank_r, rank_nxt;
  logic [CW-1:0]      scan_idx_r, scan_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               best_found_r, best_found_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [KW-1:0]      best_key_r, best_key_nxt;
  logic               fb_found_r, fb_found_nxt;
  logic [IW-1:0]      fb_idx_r, fb_idx_nxt;
  logic [ENTRIES-1:0] taken_r, taken_nxt;
  logic [IW-1:0]      sel_r, sel_nxt;
  logic [KW-1:0]      key_r, key_nxt;

  logic          ram_we;
  logic [KW-1:0] rd_data;
  logic          issue;
  logic          rd_untaken;
  logic          take_best;

  assign ram_we = cmd.load && (count_r < CW'(ENTRIES));

  fss_ram #(
    .WIDTH(KW),
    .DEPTH(ENTRIES)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[IW-1:0]),
    .wdata(in_data.fitness_key),
    .raddr(scan_idx_r[IW-1:0]),
    .rdata(rd_data)
  );

  assign issue      = scan_idx_r < count_r;
  assign rd_untaken = !taken_r[rd_idx_r];
  assign take_best  = rd_vld_r && rd_untaken && (rd_data < ceiling_r) &&
                      (!best_found_r || (rd_data < best_key_r));

  always_comb begin
    ceiling_nxt    = ceiling_r;
    count_nxt      = count_r;
    rank_nxt       = rank_r;
    scan_idx_nxt   = scan_idx_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    fb_found_nxt   = fb_found_r;
    fb_idx_nxt     = fb_idx_r;
    taken_nxt      = taken_r;
    sel_nxt        = sel_r;
    key_nxt        = key_r;

    if (cfg_we) begin
      ceiling_nxt = cfg_data;
    end

    if (ram_we) begin
      count_nxt = count_r + CW'(1);
    end

    if (cmd.scan_clear) begin
      scan_idx_nxt   = '0;
      rd_vld_nxt     = 1'b0;
      best_found_nxt = 1'b0;
      fb_found_nxt   = 1'b0;
    end

    if (cmd.scan_run) begin
      rd_vld_nxt = issue;
      rd_idx_nxt = scan_idx_r[IW-1:0];
      if (issue) begin
        scan_idx_nxt = scan_idx_r + CW'(1);
      end
      if (take_best) begin
        best_found_nxt = 1'b1;
        best_idx_nxt   = rd_idx_r;
        best_key_nxt   = rd_data;
      end
      if (rd_vld_r && rd_untaken && !fb_found_r) begin
        fb_found_nxt = 1'b1;
        fb_idx_nxt   = rd_idx_r;
      end
    end

    if (cmd.capture) begin
      sel_nxt            = best_found_r ? best_idx_r : fb_idx_r;
      key_nxt            = best_found_r ? best_key_r : ceiling_r;
      taken_nxt[sel_nxt] = 1'b1;
    end

    if (cmd.advance) begin
      rank_nxt = rank_r + CW'(1);
    end

    if (cmd.set_clear) begin
      rank_nxt  = '0;
      count_nxt = '0;
      taken_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r    <= fss_pkg::CEILING_RESET;
      count_r      <= '0;
      rank_r       <= '0;
      scan_idx_r   <= '0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      fb_found_r   <= 1'b0;
      taken_r      <= '0;
    end else begin
      ceiling_r    <= ceiling_nxt;
      count_r      <= count_nxt;
      rank_r       <= rank_nxt;
      scan_idx_r   <= scan_idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      best_found_r <= best_found_nxt;
      fb_found_r   <= fb_found_nxt;
      taken_r      <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    fb_idx_r   <= fb_idx_nxt;
    sel_r      <= sel_nxt;
    key_r      <= key_nxt;
  end

  assign sts.scan_done = !rd_vld_r && (scan_idx_r == count_r);
  assign sts.last_rank = rank_r == (count_r - CW'(1));

  assign out_data.rank         = fss_pkg::RANK_W'(rank_r);
  assign out_data.entry_index  = fss_pkg::RANK_W'(sel_r);
  assign out_data.sorted_key   = key_r;
  assign out_data.final_result = sts.last_rank;

endmodule

// ----- hdl/fss_checker.sv -----
`timescale 1ns / 1ps
`include "fitness_selection_sorter_defines.svh"
module fss_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input fss_pkg::in_beat_t         in_data,
  input logic                      out_valid,
  input logic                      out_ready,
  input fss_pkg::out_beat_t        out_data
);

  `FSS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `FSS_ASSERT(a_no_load_while_out, !(in_ready && out_valid))
  `FSS_ASSERT(a_last_in_stalls, in_valid && in_ready && in_data.is_last |=> !in_ready && !out_valid)
  `FSS_ASSERT(a_final_frees_in, out_valid && out_ready && out_data.final_result |=> in_ready)
  `FSS_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid)

endmodule

bind fitness_selection_sorter fss_checker u_fss_checker (.*);
